// ===== hdl/i2cbb_pkg.sv =====
// types and constants shared by the i2c bit sequencer files
package i2cbb_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned BITCNT_W = 4;

    localparam logic [TICK_W-1:0]   PHASE_TICKS_RESET = 16'd5;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE     = 4'd8;
    localparam logic [PHASE_W-1:0]  START_PHASES      = 3'd5;
    localparam logic [PHASE_W-1:0]  STOP_PHASES       = 3'd4;
    localparam logic [PHASE_W-1:0]  ACK_PHASES        = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [PHASE_W-1:0]  phase;
        logic [BITCNT_W-1:0] bit_cnt;
        logic [TICK_W-1:0]   tick;
        logic [BYTE_W-1:0]   shifter;
        logic                scl;
        logic                sda;
        logic                ack;
        logic [BYTE_W-1:0]   rdata;
    } t_state;

    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              busy;
        logic              done;
        logic              ack;
        logic [BYTE_W-1:0] read_data;
    } t_result;

endpackage

// ===== hdl/i2cbb_step.sv =====
// one tick of the pin sequencer: next state and result from state and item
module i2cbb_step (
    input  i2cbb_pkg::t_state              i_state,
    input  logic [2:0]                     i_operation,
    input  logic [i2cbb_pkg::BYTE_W-1:0]   i_tx_byte,
    input  logic                           i_sda_in,
    input  logic [i2cbb_pkg::TICK_W-1:0]   i_phase_ticks,
    output i2cbb_pkg::t_state              o_state,
    output i2cbb_pkg::t_result             o_result
);

    always_comb begin
        i2cbb_pkg::t_state n;
        logic done;
        logic apply;
        logic last_tick;

        n         = i_state;
        done      = 1'b0;
        apply     = 1'b0;
        last_tick = ({1'b0, i_state.tick} + 17'd1) >= {1'b0, i_phase_ticks};

        if (i_state.op == i2cbb_pkg::OP_NONE) begin
            if (i_operation == i2cbb_pkg::OP_START || i_operation == i2cbb_pkg::OP_STOP ||
                i_operation == i2cbb_pkg::OP_WRITE || i_operation == i2cbb_pkg::OP_READ) begin
                n.op      = i2cbb_pkg::t_op'(i_operation);
                n.phase   = '0;
                n.bit_cnt = '0;
                n.tick    = '0;
                if (i_operation == i2cbb_pkg::OP_WRITE) begin
                    n.shifter = i_tx_byte;
                end
                if (i_operation == i2cbb_pkg::OP_READ) begin
                    n.shifter = '0;
                    n.sda     = 1'b1;
                end
                apply = 1'b1;
            end
        end else if (!last_tick) begin
            n.tick = i_state.tick + 16'd1;
        end else begin
            n.tick = '0;
            // end of phase: sample if due, then step the phase
            unique case (i_state.op)
                i2cbb_pkg::OP_START: begin
                    n.phase = i_state.phase + 3'd1;
                    apply   = (n.phase < i2cbb_pkg::START_PHASES);
                end
                i2cbb_pkg::OP_STOP: begin
                    n.phase = i_state.phase + 3'd1;
                    apply   = (n.phase < i2cbb_pkg::STOP_PHASES);
                end
                i2cbb_pkg::OP_WRITE: begin
                    if (i_state.bit_cnt < i2cbb_pkg::BITS_PER_BYTE) begin
                        if (i_state.phase == 3'd2) begin
                            n.shifter = {i_state.shifter[i2cbb_pkg::BYTE_W-2:0], 1'b0};
                            n.bit_cnt = i_state.bit_cnt + 4'd1;
                            n.phase   = '0;
                        end else begin
                            n.phase = i_state.phase + 3'd1;
                        end
                        apply = 1'b1;
                    end else begin
                        if (i_state.phase == 3'd2) begin
                            n.ack = i_sda_in;
                        end
                        n.phase = i_state.phase + 3'd1;
                        apply   = (n.phase < i2cbb_pkg::ACK_PHASES);
                    end
                end
                i2cbb_pkg::OP_READ: begin
                    if (i_state.phase == 3'd0) begin
                        n.shifter = {i_state.shifter[i2cbb_pkg::BYTE_W-2:0], i_sda_in};
                        n.phase   = 3'd1;
                        apply     = 1'b1;
                    end else begin
                        n.phase   = '0;
                        n.bit_cnt = i_state.bit_cnt + 4'd1;
                        if (n.bit_cnt >= i2cbb_pkg::BITS_PER_BYTE) begin
                            n.rdata = i_state.shifter;
                        end else begin
                            apply = 1'b1;
                        end
                    end
                end
                default: begin
                    apply = 1'b0;
                end
            endcase
            if (!apply) begin
                n.op      = i2cbb_pkg::OP_NONE;
                n.phase   = '0;
                n.bit_cnt = '0;
                done      = 1'b1;
            end
        end

        // pin write of the phase now entered
        if (apply) begin
            unique case (n.op)
                i2cbb_pkg::OP_START: begin
                    if (n.phase == 3'd0 || n.phase == 3'd4) begin
                        n.scl = 1'b0;
                    end else if (n.phase == 3'd1) begin
                        n.sda = 1'b1;
                    end else if (n.phase == 3'd2) begin
                        n.scl = 1'b1;
                    end else begin
                        n.sda = 1'b0;
                    end
                end
                i2cbb_pkg::OP_STOP: begin
                    if (n.phase == 3'd0) begin
                        n.scl = 1'b0;
                    end else if (n.phase == 3'd1) begin
                        n.sda = 1'b0;
                    end else if (n.phase == 3'd2) begin
                        n.scl = 1'b1;
                    end else begin
                        n.sda = 1'b1;
                    end
                end
                i2cbb_pkg::OP_WRITE: begin
                    if (n.bit_cnt < i2cbb_pkg::BITS_PER_BYTE) begin
                        if (n.phase == 3'd0) begin
                            n.scl = 1'b0;
                        end else if (n.phase == 3'd1) begin
                            n.sda = n.shifter[i2cbb_pkg::BYTE_W-1];
                        end else begin
                            n.scl = 1'b1;
                        end
                    end else begin
                        if (n.phase == 3'd0 || n.phase == 3'd3) begin
                            n.scl = 1'b0;
                        end else if (n.phase == 3'd1) begin
                            n.sda = 1'b1;
                        end else begin
                            n.scl = 1'b1;
                        end
                    end
                end
                i2cbb_pkg::OP_READ: begin
                    n.scl = (n.phase == 3'd0);
                end
                default: begin
                    n.scl = n.scl;
                end
            endcase
        end

        o_state            = n;
        o_result.scl       = n.scl;
        o_result.sda_out   = n.sda;
        o_result.busy      = (n.op != i2cbb_pkg::OP_NONE);
        o_result.done      = done;
        o_result.ack       = n.ack;
        o_result.read_data = n.rdata;
    end

endmodule

// ===== hdl/i2c_bitbang_master.sv =====
// top level of the i2c bit sequencer: item and result registers, state, config
//
// I2C master pin sequencer for one bus. Each accepted item is one tick of the
// sequencer: it carries a command code (taken only while idle), the byte for a
// write, and the SDA level seen on that tick. Each item yields exactly one result
// with the driven SCL and SDA levels, busy and done flags, the last write's ack
// and the last read byte. Start, stop, write byte (with ack sample) and read byte
// (no master ack, SDA released) are supported; each pin phase is held for
// phase_ticks items, where zero acts as one. The block takes one item per clock
// while its results are taken. A result is registered: the item register feeds
// one pass of the step logic straight into the result register. The item and
// result registers each hold one entry, so a stalled result consumer stops
// intake only once both are full. phase_ticks is written through i_cfg_we and
// i_cfg_data and resets to 5; the user must write it only while idle, as the
// block itself does not enforce this.
module i2c_bitbang_master (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [i2cbb_pkg::TICK_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [2:0]                     i_operation,
    input  logic [i2cbb_pkg::BYTE_W-1:0]   i_tx_byte,
    input  logic                           i_sda_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_scl,
    output logic                           o_sda_out,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_ack,
    output logic [i2cbb_pkg::BYTE_W-1:0]   o_read_data
);

    // item register
    logic                         r_in_valid;
    logic [2:0]                   r_operation;
    logic [i2cbb_pkg::BYTE_W-1:0] r_tx_byte;
    logic                         r_sda_in;

    // sequencer state and config
    i2cbb_pkg::t_state            r_state;
    i2cbb_pkg::t_state            n_state;
    logic [i2cbb_pkg::TICK_W-1:0] r_phase_ticks;

    // result register
    logic                         r_out_valid;
    i2cbb_pkg::t_result           r_result;
    i2cbb_pkg::t_result           n_result;

    logic advance;
    logic in_fire;

    // the step runs when an item is held and the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    i2cbb_step u_step (
        .i_state       (r_state),
        .i_operation   (r_operation),
        .i_tx_byte     (r_tx_byte),
        .i_sda_in      (r_sda_in),
        .i_phase_ticks (r_phase_ticks),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase_ticks <= i2cbb_pkg::PHASE_TICKS_RESET;
            r_state.op      <= i2cbb_pkg::OP_NONE;
            r_state.phase   <= '0;
            r_state.bit_cnt <= '0;
            r_state.tick    <= '0;
            r_state.shifter <= '0;
            r_state.scl     <= 1'b1;
            r_state.sda     <= 1'b1;
            r_state.ack     <= 1'b1;
            r_state.rdata   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_data;
            end
            // item register loads on intake, drains on a step
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_operation <= i_operation;
            r_tx_byte   <= i_tx_byte;
            r_sda_in    <= i_sda_in;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl       = r_result.scl;
    assign o_sda_out   = r_result.sda_out;
    assign o_busy_res  = r_result.busy;
    assign o_done_res  = r_result.done;
    assign o_ack       = r_result.ack;
    assign o_read_data = r_result.read_data;

endmodule

// ===== hdl/i2cbb_checker.sv =====
// port checker for the i2c bit sequencer and its bind
module i2cbb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_scl,
    input logic                           o_sda_out,
    input logic                           o_busy_res,
    input logic                           o_done_res,
    input logic                           o_ack,
    input logic [i2cbb_pkg::BYTE_W-1:0]   o_read_data
);

    // a finished command is no longer busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done with busy set");

    // an empty result side never blocks intake
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("intake blocked with no result pending");

    // nothing shows right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_scl) &&
            $stable(o_sda_out) && $stable(o_busy_res) && $stable(o_done_res) &&
            $stable(o_ack) && $stable(o_read_data)))
        else $error("stalled result changed");

endmodule

bind i2c_bitbang_master i2cbb_checker u_checker (.*);
